@@ sv/mtgd_pkg.sv @@
// Shared types and constants for the multibyte text glyph decoder.
// Used by the decode logic, the command queue and the top level.
package mtgd_pkg;

    typedef enum logic [1:0] {
        LANG_SINGLE = 2'd0,
        LANG_SJIS   = 2'd1,
        LANG_EUC_JP = 2'd2,
        LANG_EUC_CN = 2'd3
    } t_lang;

    localparam logic [1:0] FONT_HALF = 2'd0;
    localparam logic [1:0] FONT_JP   = 2'd1;
    localparam logic [1:0] FONT_CN   = 2'd2;

    localparam logic       KIND_HALF = 1'b0;
    localparam logic       KIND_FULL = 1'b1;

    localparam logic [11:0] PEN_MAX    = 12'd4095;
    localparam logic [12:0] PEN_STEP   = 13'd8;
    localparam logic [19:0] JP_PAIR_BASE = 20'd4096;
    localparam logic [19:0] HALF_STEP  = 20'd16;

    typedef struct packed {
        logic [1:0]         font_table;
        logic signed [19:0] glyph_offset;
        logic signed [12:0] draw_x;
        logic [11:0]        draw_y;
        logic [7:0]         draw_color;
        logic               glyph_kind;
        logic               last;
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd0;
        t_cmd       cmd1;
        logic [1:0] cmd_cnt;
        logic [7:0] lead_next;
        logic [11:0] pen_next;
    } t_dec;

endpackage

@@ sv/mtgd_decode.sv @@
// Byte decoder: turns one text byte, the pending lead byte and the pen into
// up to two glyph commands plus the next lead byte and pen. Uses mtgd_pkg.
module mtgd_decode (
    input  mtgd_pkg::t_lang i_lang,
    input  logic [7:0]      i_lead,
    input  logic [11:0]     i_pen,
    input  logic [7:0]      i_text_byte,
    input  logic            i_first_of_string,
    input  logic [11:0]     i_start_x,
    input  logic [11:0]     i_start_y,
    input  logic [7:0]      i_color,
    output mtgd_pkg::t_dec  o_dec
);
    import mtgd_pkg::*;

    logic [11:0]        x;
    logic [12:0]        x_sum;
    logic signed [12:0] x_here;
    logic signed [12:0] x_left;
    logic signed [9:0]  lb;
    logic signed [9:0]  tb;
    logic signed [9:0]  d;
    logic signed [9:0]  k;
    logic signed [9:0]  t;
    logic signed [15:0] k_ext;
    logic signed [15:0] idx;
    logic [20:0]        off_raw;
    logic [19:0]        off_pair;
    logic [19:0]        off_single;
    logic               is_lead;

    always_comb begin
        x       = i_first_of_string ? i_start_x : i_pen;
        x_here  = signed'({1'b0, x});
        x_left  = x_here - signed'(PEN_STEP);
        x_sum   = {1'b0, x} + PEN_STEP;
        lb      = signed'({2'b00, i_lead});
        tb      = signed'({2'b00, i_text_byte});
        off_single = {8'd0, i_text_byte, 4'd0};

        d = '0;
        if (i_lang == LANG_SJIS) begin
            if (i_lead >= 8'h81 && i_lead <= 8'h9f) begin
                d = lb - 10'sd129;
                k = {d[8:0], 1'b0};
            end else begin
                d = lb - 10'sd224;
                k = {d[8:0], 1'b0} + 10'sd62;
            end
            if (i_text_byte >= 8'h40 && i_text_byte <= 8'h7e) begin
                t = tb - 10'sd64;
            end else if (i_text_byte >= 8'h80 && i_text_byte <= 8'h9e) begin
                t = tb - 10'sd65;
            end else begin
                t = tb - 10'sd159;
                k = k + 10'sd1;
            end
        end else begin
            k = lb - 10'sd161;
            t = tb - 10'sd161;
        end
        k_ext    = 16'(k);
        idx      = k_ext * 16'sd94 + 16'(t);
        off_raw  = {idx, 5'd0};
        off_pair = off_raw[19:0];

        case (i_lang)
            LANG_SJIS:   is_lead = (i_text_byte >= 8'h81 && i_text_byte <= 8'h9f) ||
                                   (i_text_byte >= 8'he0 && i_text_byte <= 8'hfc);
            LANG_EUC_JP: is_lead = (i_text_byte >= 8'h81 && i_text_byte <= 8'hfe);
            LANG_EUC_CN: is_lead = (i_text_byte >= 8'ha1 && i_text_byte <= 8'hfe);
            default:     is_lead = 1'b0;
        endcase

        o_dec.cmd0.font_table   = FONT_HALF;
        o_dec.cmd0.glyph_offset = signed'(off_single);
        o_dec.cmd0.draw_x       = x_here;
        o_dec.cmd0.draw_y       = i_start_y;
        o_dec.cmd0.draw_color   = i_color;
        o_dec.cmd0.glyph_kind   = KIND_HALF;
        o_dec.cmd0.last         = 1'b1;
        o_dec.cmd1              = o_dec.cmd0;
        o_dec.cmd_cnt           = 2'd1;
        o_dec.lead_next         = i_lead;
        o_dec.pen_next          = (x_sum > {1'b0, PEN_MAX}) ? PEN_MAX : x_sum[11:0];

        if (i_lang == LANG_SINGLE) begin
            o_dec.cmd_cnt = 2'd1;
        end else if (i_lead == 8'd0) begin
            if (is_lead) begin
                o_dec.lead_next = i_text_byte;
                o_dec.cmd_cnt   = 2'd0;
            end else begin
                o_dec.cmd0.font_table = (i_lang == LANG_EUC_CN) ? FONT_HALF : FONT_JP;
            end
        end else begin
            o_dec.lead_next = 8'd0;
            o_dec.cmd0.draw_x = x_left;
            if (i_lang == LANG_EUC_CN) begin
                o_dec.cmd0.font_table   = FONT_CN;
                o_dec.cmd0.glyph_offset = signed'(off_pair);
                o_dec.cmd0.glyph_kind   = KIND_FULL;
            end else begin
                o_dec.cmd_cnt           = 2'd2;
                o_dec.cmd0.font_table   = FONT_JP;
                o_dec.cmd0.glyph_offset = signed'(off_pair + JP_PAIR_BASE);
                o_dec.cmd0.last         = 1'b0;
                o_dec.cmd1.font_table   = FONT_JP;
                o_dec.cmd1.glyph_offset = signed'(off_pair + JP_PAIR_BASE + HALF_STEP);
                o_dec.cmd1.draw_x       = x_here;
            end
        end
    end

endmodule

@@ sv/mtgd_cmd_queue.sv @@
// Four-entry command queue: takes zero, one or two commands per cycle and
// hands out one per cycle under valid/stall. Uses mtgd_pkg.
module mtgd_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [1:0]     i_push_cnt,
    input  mtgd_pkg::t_cmd i_cmd0,
    input  mtgd_pkg::t_cmd i_cmd1,
    output logic           o_room2,
    output logic           o_valid,
    input  logic           i_stall,
    output mtgd_pkg::t_cmd o_cmd
);
    import mtgd_pkg::*;

    t_cmd       r_mem [4];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_cnt;
    logic [1:0] n_wr;
    logic [1:0] n_rd;
    logic [2:0] n_cnt;
    logic       pop;
    logic [1:0] wr1;

    always_comb begin
        pop     = (r_cnt != 3'd0) && !i_stall;
        wr1     = r_wr + 2'd1;
        n_wr    = r_wr + i_push_cnt;
        n_rd    = pop ? r_rd + 2'd1 : r_rd;
        n_cnt   = r_cnt + {1'b0, i_push_cnt} - {2'b00, pop};
        o_room2 = (r_cnt <= 3'd2);
        o_valid = (r_cnt != 3'd0);
        o_cmd   = r_mem[r_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_cmd0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wr1] <= i_cmd1;
        end
    end

endmodule

@@ sv/multibyte_text_glyph_decoder.sv @@
// Multibyte text glyph decoder: text bytes in, glyph draw commands out.
// Commands: the commands of an accepted byte are registered into the command queue.
// Throughput: one byte per cycle while the four-entry command queue has room for two;
// the two halves of a JP pair leave the queue as two commands in turn.
// Reset: synchronous, active low; clears mode, pending lead byte, pen and queue.
module multibyte_text_glyph_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_text_byte,
    input  logic               i_first_of_string,
    input  logic [11:0]        i_start_x,
    input  logic [11:0]        i_start_y,
    input  logic [7:0]         i_color,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_font_table,
    output logic signed [19:0] o_glyph_offset,
    output logic signed [12:0] o_draw_x,
    output logic [11:0]        o_draw_y,
    output logic [7:0]         o_draw_color,
    output logic               o_glyph_kind,
    output logic               o_last
);
    import mtgd_pkg::*;

    t_lang       r_lang;
    logic [7:0]  r_lead;
    logic [11:0] r_pen;
    t_dec        dec;
    t_cmd        out_cmd;
    logic        room2;
    logic        accept;
    logic [1:0]  push_cnt;

    mtgd_decode u_decode (
        .i_lang            (r_lang),
        .i_lead            (r_lead),
        .i_pen             (r_pen),
        .i_text_byte       (i_text_byte),
        .i_first_of_string (i_first_of_string),
        .i_start_x         (i_start_x),
        .i_start_y         (i_start_y),
        .i_color           (i_color),
        .o_dec             (dec)
    );

    assign o_in_stall = !room2;
    assign accept     = i_in_valid && room2;
    assign push_cnt   = accept ? dec.cmd_cnt : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lang <= LANG_SINGLE;
            r_lead <= '0;
            r_pen  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_lang <= t_lang'(i_cfg_data);
            end
            if (accept) begin
                r_lead <= dec.lead_next;
                r_pen  <= dec.pen_next;
            end
        end
    end

    mtgd_cmd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_cmd0     (dec.cmd0),
        .i_cmd1     (dec.cmd1),
        .o_room2    (room2),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_cmd      (out_cmd)
    );

    assign o_font_table   = out_cmd.font_table;
    assign o_glyph_offset = out_cmd.glyph_offset;
    assign o_draw_x       = out_cmd.draw_x;
    assign o_draw_y       = out_cmd.draw_y;
    assign o_draw_color   = out_cmd.draw_color;
    assign o_glyph_kind   = out_cmd.glyph_kind;
    assign o_last         = out_cmd.last;

endmodule

@@ test/glyph_cmd_checker.sv @@
// Watches the byte and command channels of the multibyte text glyph decoder,
// predicts the glyph commands of every accepted byte and compares them in order.
// Depends on mtgd_pkg for the language modes, font codes and command layout.
module glyph_cmd_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [7:0]         i_text_byte,
    input  logic               i_first_of_string,
    input  logic [11:0]        i_start_x,
    input  logic [11:0]        i_start_y,
    input  logic [7:0]         i_color,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [1:0]         i_font_table,
    input  logic signed [19:0] i_glyph_offset,
    input  logic signed [12:0] i_draw_x,
    input  logic [11:0]        i_draw_y,
    input  logic [7:0]         i_draw_color,
    input  logic               i_glyph_kind,
    input  logic               i_last,
    output int                 o_cmds_due,
    output int                 o_fail_count
);
    import mtgd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    t_lang      lang;
    logic [7:0] held_lead;
    int         pen;
    t_cmd       due_cmds[$];

    function automatic void queue_cmd(input logic [1:0] table_sel, input int offset,
                                      input int x, input logic [11:0] y,
                                      input logic [7:0] col, input logic kind,
                                      input logic is_last);
        t_cmd c;
        c.font_table   = table_sel;
        c.glyph_offset = offset[19:0];
        c.draw_x       = x[12:0];
        c.draw_y       = y;
        c.draw_color   = col;
        c.glyph_kind   = kind;
        c.last         = is_last;
        due_cmds.push_back(c);
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic first,
                                        input logic [11:0] sx, input logic [11:0] y,
                                        input logic [7:0] col);
        int  x;
        int  row;
        int  col_idx;
        int  lb;
        int  tb;
        int  base;
        bit  is_lead;
        if (first) begin
            pen = sx;
        end
        x = pen;
        lb = held_lead;
        tb = b;
        if (lang == LANG_SINGLE) begin
            queue_cmd(FONT_HALF, tb * 16, x, y, col, KIND_HALF, 1'b1);
        end else if (held_lead == 8'd0) begin
            case (lang)
                LANG_SJIS: is_lead = (tb >= 'h81 && tb <= 'h9f) || (tb >= 'he0 && tb <= 'hfc);
                LANG_EUC_JP: is_lead = (tb >= 'h81 && tb <= 'hfe);
                default: is_lead = (tb >= 'ha1 && tb <= 'hfe);
            endcase
            if (is_lead) begin
                held_lead = b;
            end else begin
                queue_cmd((lang == LANG_EUC_CN) ? FONT_HALF : FONT_JP, tb * 16, x, y, col,
                          KIND_HALF, 1'b1);
            end
        end else begin
            if (lang == LANG_SJIS) begin
                row = (lb <= 'h9f) ? (lb - 'h81) * 2 : (lb - 'he0) * 2 + 62;
                if (tb >= 'h40 && tb <= 'h7e) begin
                    col_idx = tb - 'h40;
                end else if (tb >= 'h80 && tb <= 'h9e) begin
                    col_idx = tb - 'h80 + 63;
                end else begin
                    col_idx = tb - 'h9f;
                    row = row + 1;
                end
            end else begin
                row = lb - 'ha1;
                col_idx = tb - 'ha1;
            end
            held_lead = 8'd0;
            if (lang == LANG_EUC_CN) begin
                queue_cmd(FONT_CN, (row * 94 + col_idx) * 32, x - 8, y, col, KIND_FULL,
                          1'b1);
            end else begin
                base = int'(JP_PAIR_BASE) + (row * 94 + col_idx) * 32;
                queue_cmd(FONT_JP, base, x - 8, y, col, KIND_HALF, 1'b0);
                queue_cmd(FONT_JP, base + 16, x, y, col, KIND_HALF, 1'b1);
            end
        end
        pen = (pen + 8 > int'(PEN_MAX)) ? int'(PEN_MAX) : pen + 8;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_cmd want;
        if (!i_rst_n) begin
            lang = LANG_SINGLE;
            held_lead = 8'd0;
            pen = 0;
            due_cmds.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (due_cmds.size() == 0) begin
                    $display("%0t: unexpected word, offset %0d x %0d", $time,
                             i_glyph_offset, i_draw_x);
                    o_fail_count++;
                end else begin
                    want = due_cmds.pop_front();
                    check_field("font_table", want.font_table, i_font_table);
                    check_field("glyph_offset", want.glyph_offset, i_glyph_offset);
                    check_field("draw_x", want.draw_x, i_draw_x);
                    check_field("draw_y", want.draw_y, i_draw_y);
                    check_field("draw_color", want.draw_color, i_draw_color);
                    check_field("glyph_kind", want.glyph_kind, i_glyph_kind);
                    check_field("last", want.last, i_last);
                end
            end
            if (i_cfg_we) begin
                lang = t_lang'(i_cfg_data);
            end
            if (i_in_valid && !i_in_stall) begin
                decode_byte(i_text_byte, i_first_of_string, i_start_x, i_start_y, i_color);
            end
        end
        o_cmds_due = due_cmds.size();
    end

endmodule

@@ test/tb.sv @@
// Top of the glyph decoder testbench: clock, reset, language mode writes,
// text byte stimulus and random output stalls around the decoder.
// Depends on mtgd_pkg, multibyte_text_glyph_decoder and glyph_cmd_checker.
module tb;
    import mtgd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_data = 2'd0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         text_byte = 8'd1;
    logic               first_of_string = 1'b0;
    logic [11:0]        start_x = 12'd0;
    logic [11:0]        start_y = 12'd0;
    logic [7:0]         color = 8'd0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         font_table;
    logic signed [19:0] glyph_offset;
    logic signed [12:0] draw_x;
    logic [11:0]        draw_y;
    logic [7:0]         draw_color;
    logic               glyph_kind;
    logic               last;
    int                 cmds_due;
    int                 fail_count;
    bit                 calm = 1'b0;

    multibyte_text_glyph_decoder DUT (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_text_byte(text_byte),
        .i_first_of_string(first_of_string), .i_start_x(start_x), .i_start_y(start_y),
        .i_color(color), .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_font_table(font_table), .o_glyph_offset(glyph_offset), .o_draw_x(draw_x),
        .o_draw_y(draw_y), .o_draw_color(draw_color), .o_glyph_kind(glyph_kind),
        .o_last(last)
    );

    glyph_cmd_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_text_byte(text_byte),
        .i_first_of_string(first_of_string), .i_start_x(start_x), .i_start_y(start_y),
        .i_color(color), .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_font_table(font_table), .i_glyph_offset(glyph_offset), .i_draw_x(draw_x),
        .i_draw_y(draw_y), .i_draw_color(draw_color), .i_glyph_kind(glyph_kind),
        .i_last(last), .o_cmds_due(cmds_due), .o_fail_count(fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        int n;
        forever begin
            n = calm ? 0 : $urandom_range(0, 3);
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic first, input logic [11:0] sx,
                             input logic [11:0] y, input logic [7:0] col);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        text_byte <= b;
        first_of_string <= first;
        start_x <= sx;
        start_y <= y;
        color <= col;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic put_byte(input logic [7:0] b);
        logic [11:0] sx;
        case ($urandom_range(0, 7))
            0: sx = 12'd0;
            1: sx = PEN_MAX;
            2: sx = PEN_MAX - 12'($urandom_range(0, 40));
            default: sx = 12'($urandom_range(0, 4095));
        endcase
        send_byte(b, $urandom_range(0, 15) == 0, sx, 12'($urandom_range(0, 4095)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic idle_wait();
        in_valid <= 1'b0;
        @(negedge clk);
        while (cmds_due != 0) @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_mode(input t_lang m);
        cfg_we <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_lead(input t_lang m);
        case (m)
            LANG_SJIS: return $urandom_range(0, 1) ? 8'($urandom_range('h81, 'h9f))
                                                   : 8'($urandom_range('he0, 'hfc));
            LANG_EUC_JP: return 8'($urandom_range('h81, 'hfe));
            default: return 8'($urandom_range('ha1, 'hfe));
        endcase
    endfunction

    function automatic logic [7:0] pick_trail(input t_lang m);
        if ($urandom_range(0, 4) == 0) begin
            return 8'($urandom_range(1, 255));
        end
        if (m == LANG_SJIS) begin
            case ($urandom_range(0, 2))
                0: return 8'($urandom_range('h40, 'h7e));
                1: return 8'($urandom_range('h80, 'h9e));
                default: return 8'($urandom_range('h9f, 'hfc));
            endcase
        end
        return 8'($urandom_range('ha1, 'hfe));
    endfunction

    initial begin
        t_lang m;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'h01, 1'b1, 12'd0, 12'd0, 8'd0);
        send_byte(8'hff, 1'b1, PEN_MAX, PEN_MAX, 8'hff);
        send_byte(8'h80, 1'b0, 12'd0, 12'd0, 8'h00);

        idle_wait();
        set_mode(LANG_SJIS);
        put_byte(8'h81);
        idle_wait();
        set_mode(LANG_SINGLE);
        put_byte(8'h41);
        idle_wait();
        set_mode(LANG_SJIS);
        send_byte(8'h40, 1'b1, 12'd0, 12'd7, 8'h5a);
        put_byte(8'h9f);
        put_byte(8'h7e);
        put_byte(8'he0);
        put_byte(8'h80);
        put_byte(8'hfc);
        put_byte(8'h9e);
        put_byte(8'h81);
        put_byte(8'h9f);
        put_byte(8'hfc);
        put_byte(8'hff);
        put_byte(8'h7f);
        put_byte(8'hfd);

        idle_wait();
        set_mode(LANG_EUC_JP);
        put_byte(8'h80);
        put_byte(8'h81);
        put_byte(8'h01);
        put_byte(8'hfe);
        put_byte(8'hfe);

        idle_wait();
        set_mode(LANG_EUC_CN);
        put_byte(8'ha0);
        put_byte(8'ha1);
        put_byte(8'h01);
        put_byte(8'hfe);
        put_byte(8'hfe);

        for (int p = 0; p < 13; p++) begin
            idle_wait();
            m = (p == 0) ? LANG_EUC_CN : (p == 1) ? LANG_SINGLE : t_lang'($urandom_range(0, 3));
            set_mode(m);
            calm = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 50; i++) begin
                if (m != LANG_SINGLE && $urandom_range(0, 9) < 6) begin
                    put_byte(pick_lead(m));
                    put_byte(pick_trail(m));
                    i++;
                end else begin
                    put_byte(8'($urandom_range(1, 255)));
                end
            end
        end
        calm = 1'b0;

        idle_wait();
        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/mtgd_pkg.sv
sv/mtgd_decode.sv
sv/mtgd_cmd_queue.sv
sv/multibyte_text_glyph_decoder.sv
test/glyph_cmd_checker.sv
test/tb.sv
